### hdl/alpe_pkg.sv
// shared types and operation codes for the positional edit list
`default_nettype none

package alpe_pkg;

	localparam int POS_W = 7;
	localparam int OUT_W = 32;
	localparam int CNT_W = 7;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_READ   = 2'd0;
	localparam kind_t KIND_INSERT = 2'd1;
	localparam kind_t KIND_DELETE = 2'd2;
	localparam kind_t KIND_RSVD   = 2'd3;

endpackage

`default_nettype wire

### hdl/array_list_positional_edit_core.sv
// Positional edit list: one request at a time, elements moved one at a time through a RAM.
// Error: answered from idle. Read: capture, finish. Delete at p: capture, one move per
// element after p, finish. Insert at p: one move per element from p on, put, finish.
// Each element move is a read then a write on the simple dual-port RAM, which sets the rate.
// The next request is taken in the cycle the result is shown; the result cannot be stalled.
// Reset clears the count and the sequencer; RAM contents are left as they are.
`default_nettype none

module array_list_positional_edit_core #(
	parameter int DEPTH      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  alpe_pkg::kind_t               kind,
	input  logic [alpe_pkg::POS_W-1:0]    position,
	input  logic [alpe_pkg::OUT_W-1:0]    value,
	output logic                          busy,
	output logic                          done,
	output logic                          status,
	output logic [alpe_pkg::OUT_W-1:0]    element,
	output logic [alpe_pkg::CNT_W-1:0]    count
);
	import alpe_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CAP     = 3'd1;
	localparam logic [2:0] S_MOVE_RD = 3'd2;
	localparam logic [2:0] S_MOVE_WR = 3'd3;
	localparam logic [2:0] S_PUT     = 3'd4;
	localparam logic [2:0] S_FIN     = 3'd5;

	logic [2:0]            state_q;
	kind_t                 kind_q;
	logic [POS_W-1:0]      pos_q;
	logic [ELEM_WIDTH-1:0] val_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         idx_q;
	logic [ELEM_WIDTH-1:0] removed_q;
	logic [ELEM_WIDTH-1:0] rd_q;
	logic                  done_q;
	logic                  status_q;
	logic [OUT_W-1:0]      element_q;
	logic [CNT_W-1:0]      count_q;

	logic [ELEM_WIDTH-1:0] mem [DEPTH];

	logic [XW-1:0]         fill_x, pos_in_x, pos_x, idx_x;
	logic [XW-1:0]         idx_dn, idx_up, pos_dn_in, pos_dn, fill_new;
	logic [63:0]           vx, rx;
	logic                  in_err, ins;
	logic                  we;
	logic [AW-1:0]         ra, wa;
	logic [ELEM_WIDTH-1:0] wd;

	assign fill_x    = XW'(fill_q);
	assign pos_in_x  = XW'(position);
	assign pos_x     = XW'(pos_q);
	assign idx_x     = XW'(idx_q);
	assign idx_dn    = idx_x - XW'(1);
	assign idx_up    = idx_x + XW'(1);
	assign pos_dn_in = pos_in_x - XW'(1);
	assign pos_dn    = pos_x - XW'(1);
	assign ins       = (kind_q == KIND_INSERT);
	assign vx        = {{32{value[OUT_W-1]}}, value};
	assign rx        = 64'(removed_q);

	always_comb begin
		case (kind) inside
			KIND_READ, KIND_DELETE: in_err = (pos_in_x == '0) || (pos_in_x > fill_x);
			KIND_INSERT: in_err = (fill_x >= DEPTH_X) || (pos_in_x == '0) ||
				(pos_in_x > fill_x + XW'(1));
			default: in_err = 1'b1;
		endcase
	end

	always_comb begin
		case (kind_q) inside
			KIND_INSERT: fill_new = fill_x + XW'(1);
			KIND_DELETE: fill_new = fill_x - XW'(1);
			default:     fill_new = fill_x;
		endcase
	end

	// RAM port control from the sequencer
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = rd_q;
		ra = idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: ra = pos_dn_in[AW-1:0];
			S_MOVE_RD: ra = ins ? idx_dn[AW-1:0] : idx_q[AW-1:0];
			S_MOVE_WR: begin
				we = 1'b1;
				wa = ins ? idx_q[AW-1:0] : idx_dn[AW-1:0];
			end
			S_PUT: begin
				we = 1'b1;
				wa = pos_dn[AW-1:0];
				wd = val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kind_q    <= KIND_READ;
			pos_q     <= '0;
			val_q     <= '0;
			fill_q    <= '0;
			idx_q     <= '0;
			removed_q <= '0;
			done_q    <= 1'b0;
			status_q  <= 1'b0;
			element_q <= '0;
			count_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q <= kind;
						pos_q  <= position;
						val_q  <= vx[ELEM_WIDTH-1:0];
						if (in_err) begin
							done_q    <= 1'b1;
							status_q  <= 1'b1;
							element_q <= '0;
							count_q   <= fill_x[CNT_W-1:0];
						end else begin
							case (kind) inside
								KIND_READ, KIND_DELETE: state_q <= S_CAP;
								KIND_INSERT: begin
									idx_q   <= fill_q;
									// append needs no moves
									state_q <= (pos_in_x <= fill_x) ? S_MOVE_RD : S_PUT;
								end
								default: state_q <= S_IDLE;
							endcase
						end
					end
				end
				S_CAP: begin
					removed_q <= rd_q;
					if (kind_q == KIND_DELETE && pos_x < fill_x) begin
						idx_q   <= pos_x[CW-1:0];
						state_q <= S_MOVE_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_MOVE_RD: state_q <= S_MOVE_WR;
				S_MOVE_WR: begin
					if (ins) begin
						idx_q   <= idx_dn[CW-1:0];
						state_q <= (idx_dn >= pos_x) ? S_MOVE_RD : S_PUT;
					end else begin
						idx_q   <= idx_up[CW-1:0];
						state_q <= (idx_up < fill_x) ? S_MOVE_RD : S_FIN;
					end
				end
				S_PUT: state_q <= S_FIN;
				S_FIN: begin
					fill_q    <= fill_new[CW-1:0];
					done_q    <= 1'b1;
					status_q  <= 1'b0;
					element_q <= ins ? '0 : rx[OUT_W-1:0];
					count_q   <= fill_new[CNT_W-1:0];
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign status  = status_q;
	assign element = element_q;
	assign count   = count_q;

endmodule

`default_nettype wire

### hdl/alpe_check.sv
// port-level checks for the positional edit list, bound to the core module
`default_nettype none

module alpe_check (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire alpe_pkg::kind_t            kind,
	input wire logic                       busy,
	input wire logic                       done,
	input wire logic                       status,
	input wire logic [alpe_pkg::OUT_W-1:0] element
);
	import alpe_pkg::*;

	// a result only appears once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted request either starts work or is answered at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither worked on nor answered");

	// an unknown operation is refused on the next cycle
	a_rsvd_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_RSVD) |=> (done && status))
		else $error("reserved operation not refused");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (element == '0))
		else $error("error result carries an element");

endmodule

bind array_list_positional_edit_core alpe_check u_alpe_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.kind    (kind),
	.busy    (busy),
	.done    (done),
	.status  (status),
	.element (element)
);

`default_nettype wire

### tb/array_list_positional_edit_core_test.sv
// self-checking testbench for the positional edit list core
`timescale 1ns / 100ps

module array_list_positional_edit_core_test;
	import alpe_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int RANDOM_EDITS = 850;

	typedef struct {
		kind_t            kind;
		logic [POS_W-1:0] position;
		logic [OUT_W-1:0] value;
	} edit_request_t;

	typedef struct {
		logic             status;
		logic [OUT_W-1:0] element;
		logic [CNT_W-1:0] count;
	} list_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	kind_t            kind = KIND_READ;
	logic [POS_W-1:0] position = '0;
	logic [OUT_W-1:0] value = '0;
	logic             busy;
	logic             done;
	logic             status;
	logic [OUT_W-1:0] element;
	logic [CNT_W-1:0] count;

	edit_request_t pending_edits[$];
	list_result_t  predicted_results[$];

	// predictor copy of the list
	logic [OUT_W-1:0] list_mem [0:LIST_DEPTH-1];
	int               list_fill = 0;

	// fill level as the stimulus generator expects it to be
	int gen_fill = 0;

	int mismatch_count = 0;
	int hold_off = 0;
	bit burst_mode = 1'b0;

	array_list_positional_edit_core #(
		.DEPTH(LIST_DEPTH),
		.ELEM_WIDTH(32)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.kind(kind),
		.position(position),
		.value(value),
		.busy(busy),
		.done(done),
		.status(status),
		.element(element),
		.count(count)
	);

	function automatic void predict_list_edit(kind_t op, logic [POS_W-1:0] pos,
			logic [OUT_W-1:0] val);
		list_result_t res;
		int p;
		p = int'(pos);
		res.status = 1'b1;
		res.element = '0;
		case (op)
		KIND_READ: begin
			if (p >= 1 && p <= list_fill) begin
				res.status = 1'b0;
				res.element = list_mem[p-1];
			end
		end
		KIND_INSERT: begin
			if (list_fill < LIST_DEPTH && p >= 1 && p <= list_fill + 1) begin
				for (int k = list_fill; k >= p; k--)
					list_mem[k] = list_mem[k-1];
				list_mem[p-1] = val;
				list_fill++;
				res.status = 1'b0;
			end
		end
		KIND_DELETE: begin
			if (p >= 1 && p <= list_fill) begin
				res.status = 1'b0;
				res.element = list_mem[p-1];
				for (int k = p; k < list_fill; k++)
					list_mem[k-1] = list_mem[k];
				list_fill--;
			end
		end
		default: begin
		end
		endcase
		res.count = list_fill[CNT_W-1:0];
		predicted_results.push_back(res);
	endfunction

	function automatic void add_edit(kind_t op, int pos, logic [OUT_W-1:0] val);
		edit_request_t req;
		req.kind = op;
		req.position = pos[POS_W-1:0];
		req.value = val;
		pending_edits.push_back(req);
		if (op == KIND_INSERT && gen_fill < LIST_DEPTH && req.position >= 1 &&
				req.position <= gen_fill + 1)
			gen_fill++;
		else if (op == KIND_DELETE && req.position >= 1 && req.position <= gen_fill)
			gen_fill--;
	endfunction

	function automatic logic [OUT_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0: pick_value = 32'h8000_0000;
		1: pick_value = 32'h7fff_ffff;
		2: pick_value = '0;
		3: pick_value = '1;
		default: pick_value = $urandom;
		endcase
	endfunction

	function automatic void add_random_edit(int phase);
		int r;
		int top;
		kind_t op;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			// noise: any kind, any position
			add_edit(kind_t'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom);
		end else begin
			case (phase)
			0: op = (r < 85) ? KIND_INSERT : (r < 92) ? KIND_READ : KIND_DELETE;
			1: op = (r < 85) ? KIND_DELETE : (r < 92) ? KIND_READ : KIND_INSERT;
			default: op = (r < 40) ? KIND_INSERT : (r < 70) ? KIND_READ : KIND_DELETE;
			endcase
			top = (op == KIND_INSERT) ? gen_fill + 1 : (gen_fill == 0 ? 1 : gen_fill);
			case ($urandom_range(0, 9))
			0: add_edit(op, 1, pick_value());
			1: add_edit(op, top, pick_value());
			default: add_edit(op, $urandom_range(1, top), pick_value());
			endcase
		end
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	// driver: presents the oldest pending request, predicts it once accepted
	always @(posedge clk) begin
		edit_request_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_list_edit(kind, position, value);
				void'(pending_edits.pop_front());
				if ($urandom_range(0, 39) == 0)
					burst_mode = ~burst_mode;
				hold_off = burst_mode ? 0 : $urandom_range(0, 6);
			end
			if (start && busy) begin
				// request still waiting, hold it
			end else if (hold_off > 0 || pending_edits.size() == 0) begin
				if (hold_off > 0)
					hold_off--;
				start <= 1'b0;
			end else begin
				nxt = pending_edits[0];
				start <= 1'b1;
				kind <= nxt.kind;
				position <= nxt.position;
				value <= nxt.value;
			end
		end
	end

	// monitor: every strobed result is matched against the oldest prediction
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (predicted_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with none pending: %s %0b element %h count %0d",
						$realtime, "status", status, element, count);
			end else begin
				want = predicted_results.pop_front();
				if (status !== want.status || element !== want.element ||
						count !== want.count) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch: expected status %0b element %h count %0d,%s",
							$realtime, want.status, want.element, want.count,
							$sformatf(" got status %0b element %h count %0d",
								status, element, count));
				end
			end
		end
	end

	initial begin
		// directed edge cases
		add_edit(KIND_READ, 1, '0);
		add_edit(KIND_DELETE, 1, '0);
		add_edit(KIND_INSERT, 0, 32'h1111_1111);
		add_edit(KIND_INSERT, 2, 32'h2222_2222);
		add_edit(KIND_RSVD, 1, '1);
		add_edit(KIND_INSERT, 1, 32'h8000_0000);
		add_edit(KIND_INSERT, 2, 32'h7fff_ffff);
		add_edit(KIND_INSERT, 1, 32'hffff_ffff);
		add_edit(KIND_INSERT, 2, 32'h0000_0000);
		add_edit(KIND_INSERT, 6, 32'h1234_5678);
		add_edit(KIND_READ, 0, '0);
		add_edit(KIND_READ, 1, '0);
		add_edit(KIND_READ, 2, '0);
		add_edit(KIND_READ, 3, '0);
		add_edit(KIND_READ, 4, '0);
		add_edit(KIND_READ, 5, '0);
		add_edit(KIND_READ, 127, '1);
		add_edit(KIND_DELETE, 127, '0);
		add_edit(KIND_INSERT, 127, 32'h5a5a_5a5a);
		add_edit(KIND_DELETE, 0, '0);
		add_edit(KIND_DELETE, 2, '0);
		add_edit(KIND_DELETE, 3, '0);
		add_edit(KIND_DELETE, 1, '0);
		add_edit(KIND_RSVD, 0, '0);

		// grow, shrink and mixed phases so the list runs full and empty
		for (int n = 0; n < RANDOM_EDITS; n++)
			add_random_edit((n / 100) % 3);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_edits.size() != 0 || start || predicted_results.size() != 0)
			@(negedge clk);
		repeat (140) @(negedge clk);

		if (mismatch_count == 0 && predicted_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
